FILE: rtl/core/psd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_pkg
// shared types and constants for the presentation-graphics segment deframer
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int BYTE_W   = 8;
    localparam int MAGIC_W  = 16;
    localparam int STAMP_W  = 32;
    localparam int LEN_W    = 16;
    localparam int POS_W    = 32;
    localparam int HIDX_W   = 4;

    localparam logic [MAGIC_W-1:0] MAGIC_RESET = 16'h5047;

    // position within the packet header
    localparam logic [HIDX_W-1:0] HDR_MAGIC_HI  = 4'd0;
    localparam logic [HIDX_W-1:0] HDR_MAGIC_LO  = 4'd1;
    localparam logic [HIDX_W-1:0] HDR_PTS_FIRST = 4'd2;
    localparam logic [HIDX_W-1:0] HDR_PTS_LAST  = 4'd5;
    localparam logic [HIDX_W-1:0] HDR_DTS_FIRST = 4'd6;
    localparam logic [HIDX_W-1:0] HDR_DTS_LAST  = 4'd9;
    localparam logic [HIDX_W-1:0] HDR_TYPE      = 4'd10;
    localparam logic [HIDX_W-1:0] HDR_LEN_HI    = 4'd11;
    localparam logic [HIDX_W-1:0] HDR_LEN_LO    = 4'd12;

    localparam logic STATUS_BYTE      = 1'b0;
    localparam logic STATUS_BAD_MAGIC = 1'b1;

    typedef struct packed {
        logic                status;
        logic [BYTE_W-1:0]   out_byte;
        logic [STAMP_W-1:0]  pts_value;
        logic [STAMP_W-1:0]  dts_value;
        logic                dts_valid;
        logic [POS_W-1:0]    packet_offset;
        logic                first_of_packet;
        logic                last_of_packet;
    } psd_result_t;

endpackage
`default_nettype wire

FILE: rtl/core/pgs_segment_deframer_top.sv
`default_nettype none
// result: an emitting byte's result is registered in the result register as the byte is accepted
// throughput: one byte per cycle while results are taken, set by the single result
// register which is refilled in the cycle it is drained
// a request waits whenever a result is held and not taken, even a header byte
// reset: parser back to magic search, offset zero, magic word 0x5047
// ----------------------------------------------------------------------------
// pgs_segment_deframer_top
// deframes a raw subtitle byte stream into segment bytes with timestamps
// ----------------------------------------------------------------------------
module pgs_segment_deframer_top
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write_en,
    input  wire logic [psd_pkg::MAGIC_W-1:0]     cfg_write_data,
    input  wire logic                            data_valid,
    output      logic                            data_ready,
    input  wire logic [psd_pkg::BYTE_W-1:0]      data_byte,
    output      logic                            result_valid,
    input  wire logic                            result_ready,
    output      logic                            status,
    output      logic [psd_pkg::BYTE_W-1:0]      out_byte,
    output      logic [psd_pkg::STAMP_W-1:0]     pts_value,
    output      logic [psd_pkg::STAMP_W-1:0]     dts_value,
    output      logic                            dts_valid,
    output      logic [psd_pkg::POS_W-1:0]       packet_offset,
    output      logic                            first_of_packet,
    output      logic                            last_of_packet
);

    logic                 step;
    logic                 emit;
    logic                 space;
    psd_pkg::psd_result_t parsed;
    psd_pkg::psd_result_t held;

    assign data_ready = space;
    assign step       = data_valid && space;

    psd_parser u_parser
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .step           (step),
        .data_byte      (data_byte),
        .emit           (emit),
        .result         (parsed)
    );

    psd_out_reg u_out_reg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (step && emit),
        .load_data    (parsed),
        .result_ready (result_ready),
        .space        (space),
        .result_valid (result_valid),
        .result_data  (held)
    );

    assign status          = held.status;
    assign out_byte        = held.out_byte;
    assign pts_value       = held.pts_value;
    assign dts_value       = held.dts_value;
    assign dts_valid       = held.dts_valid;
    assign packet_offset   = held.packet_offset;
    assign first_of_packet = held.first_of_packet;
    assign last_of_packet  = held.last_of_packet;

endmodule
`default_nettype wire

FILE: rtl/core/psd_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_parser
// header tracking and per-byte result decode, one byte per request
// ----------------------------------------------------------------------------
module psd_parser
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write_en,
    input  wire logic [psd_pkg::MAGIC_W-1:0]     cfg_write_data,
    input  wire logic                            step,
    input  wire logic [psd_pkg::BYTE_W-1:0]      data_byte,
    output      logic                            emit,
    output      psd_pkg::psd_result_t            result
);

    logic [psd_pkg::MAGIC_W-1:0] magic_word_reg;
    logic [psd_pkg::HIDX_W-1:0]  header_index_reg, header_index_next;
    logic                        in_payload_reg, in_payload_next;
    logic [psd_pkg::BYTE_W-1:0]  magic_hi_reg, magic_hi_next;
    logic [psd_pkg::STAMP_W-1:0] pts_shift_reg, pts_shift_next;
    logic [psd_pkg::STAMP_W-1:0] dts_shift_reg, dts_shift_next;
    logic [psd_pkg::BYTE_W-1:0]  length_high_reg, length_high_next;
    logic [psd_pkg::LEN_W-1:0]   bytes_remaining_reg, bytes_remaining_next;
    logic [psd_pkg::POS_W-1:0]   stream_position_reg;
    logic [psd_pkg::POS_W-1:0]   packet_start_reg, packet_start_next;

    logic [psd_pkg::LEN_W-1:0]   remaining_dec;
    logic [psd_pkg::LEN_W-1:0]   seg_length;

    assign remaining_dec = bytes_remaining_reg - psd_pkg::LEN_W'(1);
    assign seg_length    = {length_high_reg, data_byte};

    always_comb
    begin
        header_index_next    = header_index_reg;
        in_payload_next      = in_payload_reg;
        magic_hi_next        = magic_hi_reg;
        pts_shift_next       = pts_shift_reg;
        dts_shift_next       = dts_shift_reg;
        length_high_next     = length_high_reg;
        bytes_remaining_next = bytes_remaining_reg;
        packet_start_next    = packet_start_reg;

        emit                    = 1'b0;
        result.status           = psd_pkg::STATUS_BYTE;
        result.out_byte         = data_byte;
        result.pts_value        = pts_shift_reg;
        result.dts_value        = dts_shift_reg;
        result.dts_valid        = (dts_shift_reg != '0);
        result.packet_offset    = packet_start_reg;
        result.first_of_packet  = 1'b0;
        result.last_of_packet   = 1'b0;

        if (in_payload_reg)
        begin
            emit                  = 1'b1;
            bytes_remaining_next  = remaining_dec;
            if (remaining_dec == '0)
            begin
                result.last_of_packet = 1'b1;
                in_payload_next       = 1'b0;
                header_index_next     = psd_pkg::HDR_MAGIC_HI;
            end
        end
        else
        begin
            case (header_index_reg) inside
                psd_pkg::HDR_MAGIC_HI:
                begin
                    packet_start_next = stream_position_reg;
                    magic_hi_next     = data_byte;
                    header_index_next = psd_pkg::HDR_MAGIC_LO;
                end
                psd_pkg::HDR_MAGIC_LO:
                begin
                    if ({magic_hi_reg, data_byte} != magic_word_reg)
                    begin
                        // bad magic: error result, resync on the next byte
                        emit                   = 1'b1;
                        result.status          = psd_pkg::STATUS_BAD_MAGIC;
                        result.out_byte        = '0;
                        result.pts_value       = '0;
                        result.dts_value       = '0;
                        result.dts_valid       = 1'b0;
                        header_index_next      = psd_pkg::HDR_MAGIC_HI;
                    end
                    else
                    begin
                        header_index_next = psd_pkg::HDR_PTS_FIRST;
                    end
                end
                [psd_pkg::HDR_PTS_FIRST:psd_pkg::HDR_PTS_LAST]:
                begin
                    pts_shift_next    = {pts_shift_reg[psd_pkg::STAMP_W-psd_pkg::BYTE_W-1:0],
                                         data_byte};
                    header_index_next = header_index_reg + psd_pkg::HIDX_W'(1);
                end
                [psd_pkg::HDR_DTS_FIRST:psd_pkg::HDR_DTS_LAST]:
                begin
                    dts_shift_next    = {dts_shift_reg[psd_pkg::STAMP_W-psd_pkg::BYTE_W-1:0],
                                         data_byte};
                    header_index_next = header_index_reg + psd_pkg::HIDX_W'(1);
                end
                psd_pkg::HDR_TYPE:
                begin
                    emit                   = 1'b1;
                    result.first_of_packet = 1'b1;
                    header_index_next      = psd_pkg::HDR_LEN_HI;
                end
                psd_pkg::HDR_LEN_HI:
                begin
                    emit              = 1'b1;
                    length_high_next  = data_byte;
                    header_index_next = psd_pkg::HDR_LEN_LO;
                end
                default:
                begin
                    // low length byte: zero length ends the packet here
                    emit              = 1'b1;
                    header_index_next = psd_pkg::HDR_MAGIC_HI;
                    if (seg_length == '0)
                    begin
                        result.last_of_packet = 1'b1;
                    end
                    else
                    begin
                        bytes_remaining_next = seg_length;
                        in_payload_next      = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg      <= psd_pkg::MAGIC_RESET;
            header_index_reg    <= psd_pkg::HDR_MAGIC_HI;
            in_payload_reg      <= 1'b0;
            magic_hi_reg        <= '0;
            pts_shift_reg       <= '0;
            dts_shift_reg       <= '0;
            length_high_reg     <= '0;
            bytes_remaining_reg <= '0;
            stream_position_reg <= '0;
            packet_start_reg    <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                magic_word_reg <= cfg_write_data;
            end
            if (step)
            begin
                header_index_reg    <= header_index_next;
                in_payload_reg      <= in_payload_next;
                magic_hi_reg        <= magic_hi_next;
                pts_shift_reg       <= pts_shift_next;
                dts_shift_reg       <= dts_shift_next;
                length_high_reg     <= length_high_next;
                bytes_remaining_reg <= bytes_remaining_next;
                stream_position_reg <= stream_position_reg + psd_pkg::POS_W'(1);
                packet_start_reg    <= packet_start_next;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/psd_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_out_reg
// result register, refilled in the same cycle it is drained
// ----------------------------------------------------------------------------
module psd_out_reg
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire psd_pkg::psd_result_t load_data,
    input  wire logic                 result_ready,
    output      logic                 space,
    output      logic                 result_valid,
    output      psd_pkg::psd_result_t result_data
);

    logic                 valid_reg, valid_next;
    psd_pkg::psd_result_t data_reg;

    assign space = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (space)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (space && load)
        begin
            data_reg <= load_data;
        end
    end

    assign result_valid = valid_reg;
    assign result_data  = data_reg;

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the subtitle segment deframer: a directed packet
// table, then random packets, noise and bad markers under several magic words,
// each result checked against a typed row or a cycle-free model of the parser
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 100000;
    localparam int DRAIN_SLACK = 4;
    localparam int PHASE_BYTES = 390;

    typedef struct {
        logic [psd_pkg::BYTE_W-1:0] b;
        bit                         fixed_exp;
        psd_pkg::psd_result_t       res;
    } dir_row_t;

    logic                          clk;
    logic                          rst_n          = 1'b0;
    logic                          cfg_write_en   = 1'b0;
    logic [psd_pkg::MAGIC_W-1:0]   cfg_write_data = '0;
    logic                          data_valid     = 1'b0;
    logic                          data_ready;
    logic [psd_pkg::BYTE_W-1:0]    data_byte      = '0;
    logic                          result_valid;
    logic                          result_ready   = 1'b1;
    logic                          status;
    logic [psd_pkg::BYTE_W-1:0]    out_byte;
    logic [psd_pkg::STAMP_W-1:0]   pts_value;
    logic [psd_pkg::STAMP_W-1:0]   dts_value;
    logic                          dts_valid;
    logic [psd_pkg::POS_W-1:0]     packet_offset;
    logic                          first_of_packet;
    logic                          last_of_packet;

    // hand-typed expectation that travels with the current request
    bit                            row_fixed      = 1'b0;
    psd_pkg::psd_result_t          row_result     = '0;

    bit                            allow_idle     = 1'b1;
    bit                            src_idle_en    = 1'b1;
    bit                            sink_stall_en  = 1'b1;
    int                            fail_count     = 0;
    int                            cycle_count    = 0;

    // parser mirror
    logic [psd_pkg::MAGIC_W-1:0]   magic_word_cfg = psd_pkg::MAGIC_RESET;
    logic [psd_pkg::HIDX_W-1:0]    hdr_idx        = psd_pkg::HDR_MAGIC_HI;
    bit                            in_pl          = 1'b0;
    logic [psd_pkg::MAGIC_W-1:0]   magic_sr       = '0;
    logic [psd_pkg::STAMP_W-1:0]   pts_sr         = '0;
    logic [psd_pkg::STAMP_W-1:0]   dts_sr         = '0;
    logic [psd_pkg::BYTE_W-1:0]    len_hi         = '0;
    logic [psd_pkg::LEN_W-1:0]     remaining      = '0;
    logic [psd_pkg::POS_W-1:0]     stream_pos     = '0;
    logic [psd_pkg::POS_W-1:0]     pkt_start      = '0;

    psd_pkg::psd_result_t          deframed_q[$];
    dir_row_t                      dir_rows[$];

    pgs_segment_deframer_top u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .data_valid      (data_valid),
        .data_ready      (data_ready),
        .data_byte       (data_byte),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .status          (status),
        .out_byte        (out_byte),
        .pts_value       (pts_value),
        .dts_value       (dts_value),
        .dts_valid       (dts_valid),
        .packet_offset   (packet_offset),
        .first_of_packet (first_of_packet),
        .last_of_packet  (last_of_packet)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic psd_pkg::psd_result_t mk_result(input logic st, input logic [7:0] ob,
                                              input logic [31:0] pts, input logic [31:0] dts,
                                              input logic dv, input logic [31:0] off,
                                              input logic fst, input logic lst);
        psd_pkg::psd_result_t r;
        r.status          = st;
        r.out_byte        = ob;
        r.pts_value       = pts;
        r.dts_value       = dts;
        r.dts_valid       = dv;
        r.packet_offset   = off;
        r.first_of_packet = fst;
        r.last_of_packet  = lst;
        return r;
    endfunction

    function automatic psd_pkg::psd_result_t seg_byte(input logic [7:0] b, input logic fst,
                                                      input logic lst);
        return mk_result(psd_pkg::STATUS_BYTE, b, pts_sr, dts_sr, dts_sr != '0, pkt_start,
                         fst, lst);
    endfunction

    // advances the parser mirror by one stream byte
    task automatic deframe_byte(input logic [psd_pkg::BYTE_W-1:0] b, output bit got,
                                output psd_pkg::psd_result_t r);
        logic [psd_pkg::LEN_W-1:0] seg_len;
        got     = 1'b1;
        r       = '0;
        seg_len = {len_hi, b};
        if (in_pl)
        begin
            remaining = remaining - 16'd1;
            if (remaining == '0)
            begin
                r       = seg_byte(b, 1'b0, 1'b1);
                in_pl   = 1'b0;
                hdr_idx = psd_pkg::HDR_MAGIC_HI;
            end
            else
            begin
                r = seg_byte(b, 1'b0, 1'b0);
            end
        end
        else if (hdr_idx == psd_pkg::HDR_MAGIC_HI)
        begin
            pkt_start = stream_pos;
            magic_sr  = {8'h00, b};
            hdr_idx   = psd_pkg::HDR_MAGIC_LO;
            got       = 1'b0;
        end
        else if (hdr_idx == psd_pkg::HDR_MAGIC_LO)
        begin
            magic_sr = {magic_sr[7:0], b};
            if (magic_sr != magic_word_cfg)
            begin
                r       = mk_result(psd_pkg::STATUS_BAD_MAGIC, '0, '0, '0, 1'b0, pkt_start,
                                    1'b0, 1'b0);
                hdr_idx = psd_pkg::HDR_MAGIC_HI;
            end
            else
            begin
                hdr_idx = psd_pkg::HDR_PTS_FIRST;
                got     = 1'b0;
            end
        end
        else if (hdr_idx <= psd_pkg::HDR_PTS_LAST)
        begin
            pts_sr  = {pts_sr[23:0], b};
            hdr_idx = hdr_idx + 4'd1;
            got     = 1'b0;
        end
        else if (hdr_idx <= psd_pkg::HDR_DTS_LAST)
        begin
            dts_sr  = {dts_sr[23:0], b};
            hdr_idx = hdr_idx + 4'd1;
            got     = 1'b0;
        end
        else if (hdr_idx == psd_pkg::HDR_TYPE)
        begin
            r       = seg_byte(b, 1'b1, 1'b0);
            hdr_idx = psd_pkg::HDR_LEN_HI;
        end
        else if (hdr_idx == psd_pkg::HDR_LEN_HI)
        begin
            len_hi  = b;
            r       = seg_byte(b, 1'b0, 1'b0);
            hdr_idx = psd_pkg::HDR_LEN_LO;
        end
        else
        begin
            // zero length closes the packet on the length byte itself
            r = seg_byte(b, 1'b0, seg_len == '0);
            if (seg_len != '0)
            begin
                remaining = seg_len;
                in_pl     = 1'b1;
            end
            hdr_idx = psd_pkg::HDR_MAGIC_HI;
        end
        stream_pos = stream_pos + 32'd1;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        bit                   got;
        psd_pkg::psd_result_t r;
        psd_pkg::psd_result_t want;
        if (rst_n)
        begin
            if (data_valid && data_ready)
            begin
                deframe_byte(data_byte, got, r);
                if (got)
                    deframed_q.push_back(row_fixed ? row_result : r);
            end
            if (result_valid && result_ready)
            begin
                if (deframed_q.size() == 0)
                begin
                    $error("result with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    want = deframed_q.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("out_byte", 32'(want.out_byte), 32'(out_byte));
                    check_field("pts_value", want.pts_value, pts_value);
                    check_field("dts_value", want.dts_value, dts_value);
                    check_field("dts_valid", 32'(want.dts_valid), 32'(dts_valid));
                    check_field("packet_offset", want.packet_offset, packet_offset);
                    check_field("first_of_packet", 32'(want.first_of_packet),
                                32'(first_of_packet));
                    check_field("last_of_packet", 32'(want.last_of_packet),
                                32'(last_of_packet));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL pgs_segment_deframer_top");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && sink_stall_en && $urandom_range(0, 5) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                result_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [psd_pkg::BYTE_W-1:0] b, input bit fixed_exp = 1'b0,
                             input psd_pkg::psd_result_t fixed_res = '0);
        if (src_idle_en && $urandom_range(0, 5) == 0)
        begin
            data_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= b;
        row_fixed  <= fixed_exp;
        row_result <= fixed_res;
        do @(posedge clk); while (!data_ready);
    endtask

    task automatic send_packet(input logic [31:0] pts, input logic [31:0] dts,
                               input logic [7:0] seg_type, input logic [15:0] seg_len);
        send_byte(magic_word_cfg[15:8]);
        send_byte(magic_word_cfg[7:0]);
        for (int i = 3; i >= 0; i--)
            send_byte(pts[8*i +: 8]);
        for (int i = 3; i >= 0; i--)
            send_byte(dts[8*i +: 8]);
        send_byte(seg_type);
        send_byte(seg_len[15:8]);
        send_byte(seg_len[7:0]);
        for (int i = 0; i < seg_len; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // holds requests back until every expected result is out
    task automatic wait_drained();
        data_valid <= 1'b0;
        do @(posedge clk); while (deframed_q.size() != 0);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_magic(input logic [psd_pkg::MAGIC_W-1:0] v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        magic_word_cfg = v;
    endtask

    task automatic run_random(input int n_bytes, input bit with_long, input bit with_pause);
        int                        sent;
        int                        kind;
        bit                        long_done;
        bit                        pause_left;
        logic [psd_pkg::LEN_W-1:0] seg_len;
        logic [31:0]               pts;
        logic [31:0]               dts;
        sent       = 0;
        long_done  = !with_long;
        pause_left = with_pause;
        while (sent < n_bytes)
        begin
            if (allow_idle)
            begin
                src_idle_en   = ($urandom_range(0, 3) != 0);
                sink_stall_en = ($urandom_range(0, 3) != 0);
            end
            if (pause_left && sent > n_bytes / 2)
            begin
                wait_drained();
                pause_left = 1'b0;
            end
            kind = $urandom_range(0, 39);
            if (kind == 0)
            begin
                // lone byte knocks the marker search out of step
                send_byte(8'($urandom_range(0, 255)));
                sent += 1;
            end
            else if (kind < 4)
            begin
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
                sent += 2;
            end
            else if (kind < 7)
            begin
                send_byte(magic_word_cfg[15:8]);
                send_byte(magic_word_cfg[7:0] ^ 8'($urandom_range(1, 255)));
                sent += 2;
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0:       pts = '0;
                    1:       pts = '1;
                    default: pts = $urandom;
                endcase
                case ($urandom_range(0, 5))
                    0, 1:    dts = '0;
                    2:       dts = '1;
                    default: dts = $urandom;
                endcase
                if (!long_done && sent > n_bytes / 3)
                begin
                    seg_len   = 16'h0100 + 16'($urandom_range(0, 60));
                    long_done = 1'b1;
                end
                else if ($urandom_range(0, 5) == 0)
                    seg_len = '0;
                else
                    seg_len = 16'($urandom_range(1, 12));
                send_packet(pts, dts, 8'($urandom_range(0, 255)), seg_len);
                sent += 13 + seg_len;
            end
        end
    endtask

    initial
    begin
        dir_rows = '{
            '{8'h00, 1'b0, '0},
            // first pair is not the marker
            '{8'hFF, 1'b1, mk_result(psd_pkg::STATUS_BAD_MAGIC, 8'h00, 32'h0, 32'h0, 1'b0,
                                     32'd0, 1'b0, 1'b0)},
            '{8'h50, 1'b0, '0}, '{8'h47, 1'b0, '0},
            '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
            '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'h16, 1'b1, mk_result(psd_pkg::STATUS_BYTE, 8'h16, 32'hFFFF_FFFF, 32'h0, 1'b0,
                                     32'd2, 1'b1, 1'b0)},
            '{8'h00, 1'b1, mk_result(psd_pkg::STATUS_BYTE, 8'h00, 32'hFFFF_FFFF, 32'h0, 1'b0,
                                     32'd2, 1'b0, 1'b0)},
            // zero length ends the packet on its header
            '{8'h00, 1'b1, mk_result(psd_pkg::STATUS_BYTE, 8'h00, 32'hFFFF_FFFF, 32'h0, 1'b0,
                                     32'd2, 1'b0, 1'b1)},
            '{8'h50, 1'b0, '0}, '{8'h47, 1'b0, '0},
            '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'h80, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
            '{8'h80, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
            '{8'hFF, 1'b0, '0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].b, dir_rows[i].fixed_exp, dir_rows[i].res);

        wait_drained();
        write_magic(16'h0000);
        run_random(PHASE_BYTES, 1'b1, 1'b0);

        wait_drained();
        write_magic(16'hFFFF);
        run_random(PHASE_BYTES, 1'b0, 1'b1);

        wait_drained();
        write_magic(16'($urandom_range(0, 65535)));
        run_random(PHASE_BYTES, 1'b0, 1'b0);

        // closing stretch at full rate on both sides
        wait_drained();
        write_magic(psd_pkg::MAGIC_RESET);
        allow_idle    = 1'b0;
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
        run_random(PHASE_BYTES, 1'b0, 1'b0);

        wait_drained();
        if (fail_count == 0 && deframed_q.size() == 0)
            $display("PASS pgs_segment_deframer_top");
        else
            $display("FAIL pgs_segment_deframer_top");
        $finish;
    end

endmodule
`default_nettype wire
